@@ hw/rtl/per_node_sequence_reorder_core_assert.svh @@
// Assertion macros shared by the reorder core modules.
`ifndef PER_NODE_SEQUENCE_REORDER_CORE_ASSERT_SVH
`define PER_NODE_SEQUENCE_REORDER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PNSR_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define PNSR_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

@@ hw/rtl/pnsr_pkg.sv @@
// Shared types and codes of the reorder core.
package pnsr_pkg;
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_PRIO  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_RELEASED = 3'd0;
    localparam logic [2:0] ST_HELD     = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_STALE    = 3'd3;
    localparam logic [2:0] ST_AHEAD    = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  sender;
        logic [31:0] seq_num;
        logic        link_up;
        logic [15:0] msg_tag;
        logic        known;
    } item_t;

    typedef struct packed {
        logic [5:0]  sender;
        logic [31:0] seq;
        logic [15:0] tag;
        logic [2:0]  status;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RDEXP, S_DECIDE, S_SCAN, S_EMIT, S_CLOSE, S_WRITE
    } back_state_t;
endpackage

@@ hw/rtl/pnsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pnsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/pnsr_front.sv @@
// Input stage and queue: accepts items, classifies the sender range.
module pnsr_front #(
    parameter int SENDERS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pnsr_pkg::item_t  in_item,
    output logic             q_valid,
    input  logic             q_ready,
    output pnsr_pkg::item_t  q_item
);
    // Two-entry queue.
    pnsr_pkg::item_t slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;
    pnsr_pkg::item_t cls;

    always_comb
    begin
        cls = in_item;
        cls.known = ({3'b000, in_item.sender} < 9'(SENDERS));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= cls;
        end
    end

    `include "per_node_sequence_reorder_core_assert.svh"
    `PNSR_ASSERT_IMP(a_no_over, clk, rst_n, cnt_reg == 2'd2, !push, "queue overflow")
    `PNSR_ASSERT_IMP(a_no_under, clk, rst_n, cnt_reg == 2'd0, !pop, "queue underflow")
    `PNSR_ASSERT_NEXT(a_cnt, clk, rst_n, push && !pop, cnt_reg != 2'd0, "count lost")
endmodule

@@ hw/rtl/pnsr_back.sv @@
// Execution stage: counter memory, held store, scan sequencer, output register.
module pnsr_back #(
    parameter int HOLD_DEPTH = 16,
    parameter int SENDERS    = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  pnsr_pkg::item_t   q_item,
    output logic              out_valid,
    input  logic              out_ready,
    output pnsr_pkg::result_t out_res
);
    localparam int SW = (SENDERS > 1) ? $clog2(SENDERS) : 1;
    localparam int HW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    pnsr_pkg::back_state_t state_reg, state_next;
    pnsr_pkg::item_t cur_reg, cur_next;
    logic [31:0] exp_reg, exp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SENDERS-1:0] vld_reg, vld_next;

    // Release waiting to learn whether another one follows it.
    logic [31:0] pend_seq_reg, pend_seq_next;
    logic [15:0] pend_tag_reg, pend_tag_next;

    // Held store in flip-flops, read at the scan index only.
    logic [5:0]  hs_reg [HOLD_DEPTH];
    logic [31:0] hq_reg [HOLD_DEPTH];
    logic [15:0] ht_reg [HOLD_DEPTH];
    logic        ins;
    logic        del;
    logic [HW-1:0] del_pos;

    logic ov_reg, ov_next;
    pnsr_pkg::result_t res_reg, res_next;

    logic ram_we;
    logic [31:0] ram_rd;
    logic [31:0] exp_cur;
    logic [7:0]  snd_ext;
    logic [SW-1:0] snd_idx;
    logic [HW-1:0] sidx;

    assign snd_ext = {2'b00, cur_reg.sender};
    assign snd_idx = snd_ext[SW-1:0];
    assign sidx    = idx_reg[HW-1:0];
    assign exp_cur = vld_reg[snd_idx] ? ram_rd : 32'd0;

    pnsr_ram #(.WIDTH(32), .DEPTH(SENDERS)) u_exp (
        .clk(clk), .we(ram_we), .waddr(snd_idx), .wdata(exp_reg),
        .raddr(snd_idx), .rdata(ram_rd)
    );

    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        exp_next      = exp_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        vld_next      = vld_reg;
        pend_seq_next = pend_seq_reg;
        pend_tag_next = pend_tag_reg;
        ov_next       = ov_reg && !out_ready;
        res_next      = res_reg;
        q_ready       = 1'b0;
        ram_we        = 1'b0;
        ins           = 1'b0;
        del           = 1'b0;
        del_pos       = sidx;
        unique case (state_reg)
            pnsr_pkg::S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cur_next = q_item;
                    if (q_item.command == pnsr_pkg::CMD_DATA)
                    begin
                        state_next = pnsr_pkg::S_RDEXP;
                    end
                    else if (q_item.command == pnsr_pkg::CMD_CLEAR)
                    begin
                        idx_next   = '0;
                        state_next = q_item.known ? pnsr_pkg::S_SCAN : pnsr_pkg::S_CLOSE;
                    end
                    else if (q_item.command == pnsr_pkg::CMD_PRIO)
                    begin
                        state_next = pnsr_pkg::S_CLOSE;
                    end
                end
            end
            pnsr_pkg::S_RDEXP:
            begin
                state_next = pnsr_pkg::S_DECIDE;
            end
            pnsr_pkg::S_DECIDE:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    res_next = '{sender: cur_reg.sender, seq: cur_reg.seq_num,
                                 tag: cur_reg.msg_tag, status: pnsr_pkg::ST_RELEASED,
                                 last: 1'b1};
                    state_next = pnsr_pkg::S_IDLE;
                    if (!cur_reg.link_up || !cur_reg.known)
                    begin
                        res_next.status = pnsr_pkg::ST_DROPPED;
                    end
                    else if (cur_reg.seq_num == exp_cur)
                    begin
                        // The in-order message waits until the scan shows
                        // whether it is the final release.
                        ov_next       = 1'b0;
                        pend_seq_next = cur_reg.seq_num;
                        pend_tag_next = cur_reg.msg_tag;
                        exp_next      = exp_cur + 32'd1;
                        idx_next      = '0;
                        state_next    = pnsr_pkg::S_SCAN;
                    end
                    else if (cur_reg.seq_num < exp_cur)
                    begin
                        res_next.status = pnsr_pkg::ST_STALE;
                    end
                    else if ({1'b0, cur_reg.seq_num} > ({1'b0, exp_cur} + 33'(HOLD_DEPTH)))
                    begin
                        res_next.status = pnsr_pkg::ST_AHEAD;
                    end
                    else if (cnt_reg < CW'(HOLD_DEPTH))
                    begin
                        res_next.status = pnsr_pkg::ST_HELD;
                        ins      = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        res_next.status = pnsr_pkg::ST_FULL;
                    end
                end
            end
            pnsr_pkg::S_SCAN:
            begin
                // One held entry examined per cycle until a match, which moves to S_EMIT.
                if (idx_reg >= cnt_reg)
                begin
                    if (cur_reg.command == pnsr_pkg::CMD_CLEAR)
                    begin
                        exp_next   = '0;
                        state_next = pnsr_pkg::S_CLOSE;
                    end
                    else if (!ov_next)
                    begin
                        // Nothing further is next, so the waiting release ends the run.
                        ov_next    = 1'b1;
                        res_next   = '{sender: cur_reg.sender, seq: pend_seq_reg,
                                       tag: pend_tag_reg, status: pnsr_pkg::ST_RELEASED,
                                       last: 1'b1};
                        state_next = pnsr_pkg::S_WRITE;
                    end
                end
                else if (hs_reg[sidx] == cur_reg.sender &&
                         (cur_reg.command == pnsr_pkg::CMD_CLEAR || hq_reg[sidx] == exp_reg))
                begin
                    state_next = pnsr_pkg::S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            pnsr_pkg::S_EMIT:
            begin
                if (!ov_next)
                begin
                    ov_next  = 1'b1;
                    del      = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                    if (cur_reg.command == pnsr_pkg::CMD_CLEAR)
                    begin
                        res_next = '{sender: cur_reg.sender, seq: hq_reg[sidx],
                                     tag: ht_reg[sidx], status: pnsr_pkg::ST_CLEARED,
                                     last: 1'b0};
                    end
                    else
                    begin
                        // Send the waiting release; the matched entry takes its place.
                        res_next = '{sender: cur_reg.sender, seq: pend_seq_reg,
                                     tag: pend_tag_reg, status: pnsr_pkg::ST_RELEASED,
                                     last: 1'b0};
                        pend_seq_next = hq_reg[sidx];
                        pend_tag_next = ht_reg[sidx];
                        exp_next      = exp_reg + 32'd1;
                        idx_next      = '0;
                    end
                    state_next = pnsr_pkg::S_SCAN;
                end
            end
            pnsr_pkg::S_WRITE:
            begin
                ram_we     = 1'b1;
                vld_next[snd_idx] = 1'b1;
                state_next = pnsr_pkg::S_IDLE;
            end
            pnsr_pkg::S_CLOSE:
            begin
                if (!ov_next)
                begin
                    ov_next  = 1'b1;
                    res_next = '{sender: cur_reg.sender, seq: cur_reg.seq_num,
                                 tag: cur_reg.msg_tag,
                                 status: (cur_reg.link_up && cur_reg.known) ?
                                         pnsr_pkg::ST_RELEASED : pnsr_pkg::ST_DROPPED,
                                 last: 1'b1};
                    state_next = pnsr_pkg::S_IDLE;
                    if (cur_reg.command == pnsr_pkg::CMD_CLEAR)
                    begin
                        res_next.seq    = '0;
                        res_next.status = pnsr_pkg::ST_CLEARED;
                        if (cur_reg.known)
                        begin
                            ram_we = 1'b1;
                            vld_next[snd_idx] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = pnsr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pnsr_pkg::S_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        exp_reg      <= exp_next;
        idx_reg      <= idx_next;
        res_reg      <= res_next;
        pend_seq_reg <= pend_seq_next;
        pend_tag_reg <= pend_tag_next;
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            if (del && i >= int'(del_pos) && i + 1 < HOLD_DEPTH)
            begin
                hs_reg[i] <= hs_reg[i+1];
                hq_reg[i] <= hq_reg[i+1];
                ht_reg[i] <= ht_reg[i+1];
            end
        end
        if (ins)
        begin
            hs_reg[cnt_reg[HW-1:0]] <= cur_reg.sender;
            hq_reg[cnt_reg[HW-1:0]] <= cur_reg.seq_num;
            ht_reg[cnt_reg[HW-1:0]] <= cur_reg.msg_tag;
        end
    end

    `include "per_node_sequence_reorder_core_assert.svh"
    `PNSR_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= CW'(HOLD_DEPTH), "store overrun")
    `PNSR_ASSERT_IMP(a_emit_nonempty, clk, rst_n, del, cnt_reg != '0, "delete from empty store")
    `PNSR_ASSERT_IMP(a_ins_room, clk, rst_n, ins, cnt_reg < CW'(HOLD_DEPTH), "insert into full store")
    `PNSR_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && !out_ready, ov_reg, "result dropped")
endmodule

@@ hw/rtl/per_node_sequence_reorder_core.sv @@
// An input item passes the two-entry front queue, then the back stage's idle state;
// a data item goes on through the expected-value read and decide states, a priority
// item to the close state. An in-order data item scans the held store one entry per
// cycle, restarting after each release; a clear of a known sender scans it to delete
// that sender's entries. Output stalls hold every result state; a new item is taken only in idle.
// Reset (rst_n low, asynchronous) empties the store and the queue and clears every sender's valid bit.
module per_node_sequence_reorder_core #(
    parameter int HOLD_DEPTH = 16,
    parameter int SENDERS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: command[1:0], sender[7:2], seq_num[39:8], link_up[40],
    // msg_tag[56:41], zero fill [63:57].
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_sender[5:0], out_seq[37:6], out_tag[53:38], zero fill [55:54].
    output logic [55:0] m_axis_tdata,
    // tuser: status[2:0].
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    pnsr_pkg::item_t   in_item;
    pnsr_pkg::item_t   q_item;
    pnsr_pkg::result_t res;
    logic q_valid;
    logic q_ready;

    // Unpack the slave transaction; the front stage fills in the range flag.
    assign in_item = '{command: s_axis_tdata[1:0], sender: s_axis_tdata[7:2],
                       seq_num: s_axis_tdata[39:8], link_up: s_axis_tdata[40],
                       msg_tag: s_axis_tdata[56:41], known: 1'b0};

    pnsr_front #(.SENDERS(SENDERS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    pnsr_back #(.HOLD_DEPTH(HOLD_DEPTH), .SENDERS(SENDERS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    // Pack the master transaction.
    assign m_axis_tdata = {2'b00, res.tag, res.seq, res.sender};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;
endmodule
